// ----- src/bmhpq_pkg.sv -----
// Package for the binary min-heap priority queue: item types, codes and the
// command and status bundles between controller and datapath.
// Depends on nothing.
package bmhpq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VERTEX_W     = 10;
  localparam int WEIGHT_W     = 32;
  localparam int COUNT_OUT_W  = 7;
  localparam int ENTRY_W      = VERTEX_W + WEIGHT_W;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                       action;
    logic [VERTEX_W-1:0]        entry_vertex;
    logic signed [WEIGHT_W-1:0] entry_weight;
  } in_item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]        top_vertex;
    logic signed [WEIGHT_W-1:0] top_weight;
    logic [COUNT_OUT_W-1:0]     entry_count;
    logic                       is_empty;
    logic [1:0]                 status;
  } out_item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]        vertex;
    logic signed [WEIGHT_W-1:0] weight;
  } heap_entry_t;

  typedef struct packed {
    logic start_push;   // append the new entry, count up
    logic start_pop;    // count down, hole at the root
    logic refuse_push;
    logic refuse_pop;
    logic rd_last;
    logic rd_parent;
    logic rd_left;
    logic rd_right;
    logic rd_root;
    logic latch_hold;   // take the read entry as the one being sifted
    logic latch_left;
    logic wr_hold;      // final placement of the sifted entry
    logic wr_parent;    // parent moves down into the hole
    logic wr_best;      // smaller child moves up into the hole
    logic load_out;
  } bmhpq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic up_less;
    logic left_ok;
    logic right_ok;
    logic dn_move;
    logic out_free;
  } bmhpq_sts_t;

endpackage

// ----- src/bmhpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bmhpq_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/bmhpq_ctrl.sv -----
// Controller for the heap: sequences push sift-up, pop sift-down and the
// final root read. Depends on bmhpq_pkg.
module bmhpq_ctrl
  import bmhpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  bmhpq_sts_t sts,
  output bmhpq_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_POP_RD, S_POP_LD, S_UP_RD, S_UP_CMP,
    S_DN_RDL, S_DN_RDR, S_DN_CMP, S_RDTOP, S_TOPWAIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action == ACT_PUSH) begin
            if (sts.full) begin
              cmd.refuse_push = 1'b1;
              state_nxt       = S_RDTOP;
            end else begin
              cmd.start_push = 1'b1;
              state_nxt      = S_UP_RD;
            end
          end else begin
            if (sts.empty) begin
              cmd.refuse_pop = 1'b1;
              state_nxt      = S_RDTOP;
            end else begin
              cmd.start_pop = 1'b1;
              state_nxt     = S_POP_RD;
            end
          end
        end
      end
      S_POP_RD: begin
        if (sts.empty) begin
          state_nxt = S_RDTOP;
        end else begin
          cmd.rd_last = 1'b1;
          state_nxt   = S_POP_LD;
        end
      end
      S_POP_LD: begin
        cmd.latch_hold = 1'b1;
        state_nxt      = S_DN_RDL;
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.wr_hold = 1'b1;
          state_nxt   = S_RDTOP;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_less) begin
          cmd.wr_parent = 1'b1;
          state_nxt     = S_UP_RD;
        end else begin
          cmd.wr_hold = 1'b1;
          state_nxt   = S_RDTOP;
        end
      end
      S_DN_RDL: begin
        if (sts.left_ok) begin
          cmd.rd_left = 1'b1;
          state_nxt   = S_DN_RDR;
        end else begin
          cmd.wr_hold = 1'b1;
          state_nxt   = S_RDTOP;
        end
      end
      S_DN_RDR: begin
        cmd.latch_left = 1'b1;
        cmd.rd_right   = sts.right_ok;
        state_nxt      = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.dn_move) begin
          cmd.wr_best = 1'b1;
          state_nxt   = S_DN_RDL;
        end else begin
          cmd.wr_hold = 1'b1;
          state_nxt   = S_RDTOP;
        end
      end
      S_RDTOP: begin
        cmd.rd_root = 1'b1;
        state_nxt   = S_TOPWAIT;
      end
      S_TOPWAIT: begin
        // The read data register holds the root until the result slot frees.
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded while the output slot is occupied");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_push |-> !sts.full)
    else $error("push started on a full heap");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != S_IDLE)
    else $error("accepted item did not start any work");
`endif

endmodule

// ----- src/bmhpq_dp.sv -----
// Datapath for the heap: fill count, sift position, held entry, heap RAM
// and the result register. Depends on bmhpq_pkg and bmhpq_ram.
module bmhpq_dp
  import bmhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  bmhpq_cmd_t cmd,
  output bmhpq_sts_t sts,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  logic [CW-1:0] count_r;
  logic [AW-1:0] pos_r;
  heap_entry_t   hold_r, lft_r;
  logic          lwin_r;
  logic [1:0]    status_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic [AW-1:0]    pos_m1, parent_idx;
  logic [IW-1:0]    left_idx, right_idx, count_ext;
  heap_entry_t      rd_entry, best_entry;
  logic [ENTRY_W-1:0] ram_rd_data, ram_wr_data;
  logic             ram_rd_en, ram_wr_en;
  logic [AW-1:0]    ram_rd_addr, ram_wr_addr;
  logic             right_better;

  assign rd_entry   = heap_entry_t'(ram_rd_data);
  assign pos_m1     = pos_r - AW'(1);
  assign parent_idx = pos_m1 >> 1;
  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign count_ext  = IW'(count_r);

  // The best of hold and left child is registered beforehand in lwin_r.
  assign best_entry   = lwin_r ? lft_r : hold_r;
  assign right_better = sts.right_ok && (rd_entry.weight < best_entry.weight);

  always_comb begin
    sts.full     = (count_r == CW'(CAPACITY));
    sts.empty    = (count_r == '0);
    sts.pos_zero = (pos_r == '0);
    sts.up_less  = (hold_r.weight < rd_entry.weight);
    sts.left_ok  = (left_idx < count_ext);
    sts.right_ok = (right_idx < count_ext);
    sts.dn_move  = lwin_r || right_better;
    sts.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    ram_rd_en   = cmd.rd_last || cmd.rd_parent || cmd.rd_left
               || cmd.rd_right || cmd.rd_root;
    ram_rd_addr = '0;
    if (cmd.rd_last) begin
      ram_rd_addr = count_r[AW-1:0];
    end else if (cmd.rd_parent) begin
      ram_rd_addr = parent_idx;
    end else if (cmd.rd_left) begin
      ram_rd_addr = left_idx[AW-1:0];
    end else if (cmd.rd_right) begin
      ram_rd_addr = right_idx[AW-1:0];
    end
    ram_wr_en   = cmd.wr_hold || cmd.wr_parent || cmd.wr_best;
    ram_wr_addr = pos_r;
    if (cmd.wr_parent) begin
      ram_wr_data = ram_rd_data;
    end else if (cmd.wr_best) begin
      ram_wr_data = right_better ? ram_rd_data : lft_r;
    end else begin
      ram_wr_data = hold_r;
    end
  end

  bmhpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start_push) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.start_pop) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_push) begin
      hold_r.vertex <= in_data.entry_vertex;
      hold_r.weight <= in_data.entry_weight;
      pos_r         <= count_r[AW-1:0];
    end else if (cmd.start_pop) begin
      pos_r <= '0;
    end else if (cmd.wr_parent) begin
      pos_r <= parent_idx;
    end else if (cmd.wr_best) begin
      pos_r <= right_better ? right_idx[AW-1:0] : left_idx[AW-1:0];
    end
    if (cmd.latch_hold) begin
      hold_r <= rd_entry;
    end
    if (cmd.latch_left) begin
      lft_r  <= rd_entry;
      lwin_r <= (rd_entry.weight < hold_r.weight);
    end
    if (cmd.start_push || cmd.start_pop) begin
      status_r <= ST_OK;
    end else if (cmd.refuse_push) begin
      status_r <= ST_FULL;
    end else if (cmd.refuse_pop) begin
      status_r <= ST_EMPTY;
    end
    if (cmd.load_out) begin
      out_data_r.top_vertex  <= sts.empty ? '0 : rd_entry.vertex;
      out_data_r.top_weight  <= sts.empty ? '0 : rd_entry.weight;
      out_data_r.entry_count <= COUNT_OUT_W'(count_r);
      out_data_r.is_empty    <= sts.empty;
      out_data_r.status      <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_rd_en && ram_wr_en))
    else $error("heap RAM read and written in the same cycle");

  a_refuse_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.refuse_push || cmd.refuse_pop) |=> count_r == $past(count_r))
    else $error("refused item changed the fill count");
`endif

endmodule

// ----- src/binary_min_heap_priority_queue.sv -----
// Top level of the binary min-heap priority queue: joins controller and
// datapath. Depends on bmhpq_pkg, bmhpq_ctrl and bmhpq_dp.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data  (in_item_t)
//   out      output     out_valid / out_ready  out_data (out_item_t)
//
// A push climbs level by level up to the root, or stops at a parent that is not
// heavier. A pop descends level by level to a node without children, or stops
// where no child is lighter. A refused item goes straight to the root read and
// the result. Every push level costs one heap RAM read with a registered result,
// then a compare and a write; every pop level reads the left child and then the
// right one, if any, before the compare and the write. The RAM is never read and written at once.
// One item is worked on at a time; in_ready is high only while idle.
// A held result does not block the next item until that item finishes.
// Reset clears the fill count and the control state; RAM contents stay.
module binary_min_heap_priority_queue
  import bmhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  bmhpq_cmd_t cmd;
  bmhpq_sts_t sts;

  bmhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (in_data.action),
    .sts      (sts),
    .cmd      (cmd)
  );

  bmhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
